// ===== hdl/pbtt_pkg.sv =====
// Package for the postfix Boolean truth-table core.
// Holds the token codes, the stack interface structs and the vector helper functions.
// No dependencies.
package pbtt_pkg;

  // Widths fixed by the token and result formats.
  localparam int unsigned KIND_W = 4;
  localparam int unsigned VIDX_W = 3;
  localparam int unsigned NVAR_W = 3;
  localparam int unsigned VEC_W  = 64;

  // Largest variable count that the truth-table vectors can hold.
  localparam logic [NVAR_W-1:0] MAX_VARS = NVAR_W'(6);

  // Default number of vector entries on the stack.
  localparam int unsigned DEF_STACK_DEPTH = 32;

  // Token codes.
  localparam logic [KIND_W-1:0] KIND_CONST0  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_CONST1  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_VAR     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NOT     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_AND     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_OR      = 4'd5;
  localparam logic [KIND_W-1:0] KIND_XOR     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_IMPLIES = 4'd7;
  localparam logic [KIND_W-1:0] KIND_EQUIV   = 4'd8;

  // One token handed to the stack.
  typedef struct packed {
    logic              en;
    logic [KIND_W-1:0] kind;
    logic              last;
  } stk_cmd_t;

  // Stack status after the token has been applied.
  typedef struct packed {
    logic err;  // error seen in this expression, or stack empty
  } stk_stat_t;

  // Truth-table column of the variable at a given bit position of the row number.
  function automatic logic [VEC_W-1:0] bit_pattern(input logic [NVAR_W-1:0] pos);
    logic [VEC_W-1:0] v;
    begin
      case (pos)
        3'd0:    v = 64'hAAAA_AAAA_AAAA_AAAA;
        3'd1:    v = 64'hCCCC_CCCC_CCCC_CCCC;
        3'd2:    v = 64'hF0F0_F0F0_F0F0_F0F0;
        3'd3:    v = 64'hFF00_FF00_FF00_FF00;
        3'd4:    v = 64'hFFFF_0000_FFFF_0000;
        3'd5:    v = 64'hFFFF_FFFF_0000_0000;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Mask of the rows that exist for a given variable count.
  function automatic logic [VEC_W-1:0] row_mask(input logic [NVAR_W-1:0] n);
    logic [VEC_W-1:0] m;
    begin
      case (n)
        3'd0:    m = 64'h0000_0000_0000_0001;
        3'd1:    m = 64'h0000_0000_0000_0003;
        3'd2:    m = 64'h0000_0000_0000_000F;
        3'd3:    m = 64'h0000_0000_0000_00FF;
        3'd4:    m = 64'h0000_0000_0000_FFFF;
        3'd5:    m = 64'h0000_0000_FFFF_FFFF;
        default: m = '1;
      endcase
      return m;
    end
  endfunction

  // Binary operators; b is the top of the stack and a the entry below it.
  function automatic logic [VEC_W-1:0] bin_op(input logic [KIND_W-1:0] kind,
                                              input logic [VEC_W-1:0] a,
                                              input logic [VEC_W-1:0] b);
    logic [VEC_W-1:0] r;
    begin
      case (kind)
        KIND_AND:     r = a & b;
        KIND_OR:      r = a | b;
        KIND_XOR:     r = a ^ b;
        KIND_IMPLIES: r = ~a | b;
        default:      r = ~(a ^ b);
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/pbtt_stack.sv =====
// Vector stack of the postfix Boolean truth-table core.
// Top entry in a register, the rest in a memory with a registered read port.
// Depends on pbtt_pkg.
module pbtt_stack
  import pbtt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stk_cmd_t         cmd,
  input  logic [VEC_W-1:0] push_vec,
  output logic [VEC_W-1:0] top_d,
  output stk_stat_t        stat
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);

  logic [SPW-1:0]   sp_r, sp_d, sp_nxt;
  logic             err_r, err_d, err_nxt;
  logic [VEC_W-1:0] top_r;
  logic [VEC_W-1:0] mem [STACK_DEPTH];
  logic [VEC_W-1:0] mem_q;
  logic             byp_r;
  logic [VEC_W-1:0] byp_data_r;
  logic [VEC_W-1:0] second;
  logic             wr_en;
  logic             fault;
  logic [SPW-1:0]   wr_sp;
  logic [SPW-1:0]   rd_sp;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  // The entry below the top: from the memory, or the word just written to it.
  assign second = byp_r ? byp_data_r : mem_q;

  // Apply one token to the stack.
  always_comb begin
    sp_d  = sp_r;
    top_d = top_r;
    wr_en = 1'b0;
    fault = 1'b0;
    if (cmd.en) begin
      unique case (cmd.kind) inside
        KIND_CONST0, KIND_CONST1, KIND_VAR: begin
          if (sp_r == SPW'(STACK_DEPTH)) begin
            fault = 1'b1;
          end else begin
            wr_en = (sp_r != '0);
            top_d = push_vec;
            sp_d  = sp_r + SPW'(1);
          end
        end
        KIND_NOT: begin
          if (sp_r == '0) begin
            fault = 1'b1;
          end else begin
            top_d = ~top_r;
          end
        end
        [KIND_AND:KIND_EQUIV]: begin
          if (sp_r < SPW'(2)) begin
            fault = 1'b1;
          end else begin
            top_d = bin_op(cmd.kind, second, top_r);
            sp_d  = sp_r - SPW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    err_d    = err_r | fault;
    stat.err = err_d | (sp_d == '0);
    // The last token of an expression empties the stack.
    sp_nxt  = (cmd.en && cmd.last) ? '0 : sp_d;
    err_nxt = (cmd.en && cmd.last) ? 1'b0 : err_d;
  end

  // Old top goes to memory on a push; the read port fetches the new second entry.
  assign wr_sp   = sp_r - SPW'(1);
  assign rd_sp   = sp_nxt - SPW'(2);
  assign wr_addr = wr_sp[AW-1:0];
  assign rd_addr = rd_sp[AW-1:0];

  // Control state. A last token leaves the stack empty, so nothing is bypassed after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      err_r <= 1'b0;
      byp_r <= 1'b0;
    end else begin
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
      byp_r <= wr_en && !cmd.last && (wr_addr == rd_addr);
    end
  end

  // Top register and bypass word.
  always_ff @(posedge clk) begin
    top_r      <= top_d;
    byp_data_r <= top_r;
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    mem_q <= mem[rd_addr];
  end

  // The pointer never passes the depth.
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // A last token leaves an empty, error-free stack.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.en && cmd.last) |=> (sp_r == '0) && !err_r)
    else $error("stack not cleared after last token");

  // A bypassed word only follows a push onto a non-empty stack.
  a_byp_depth: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (sp_r >= SPW'(2)))
    else $error("bypass with fewer than two entries");

endmodule

// ===== hdl/postfix_boolean_truth_table_core.sv =====
// Postfix Boolean truth-table core: one token word is accepted per clock cycle
// when the result side is free, so the sustained rate is one token per cycle.
// A token passes an input register and then one stage that updates the vector
// stack and, on the token marked last, loads the result register; a result word
// is valid once that stage has executed its last token. The stack keeps its top
// entry in a register and the rest in a memory whose registered read port is
// aimed each cycle at the entry that will sit below the top, so pushes, pops and
// operators follow each other without pause. A new last token waits only while
// the previous result word is still held by the output side. num_vars is to be
// written through the configuration port while no expression is in progress; the
// user must keep to this, as the block itself does not enforce it.
//
// Depends on pbtt_pkg and pbtt_stack.
module postfix_boolean_truth_table_core
  import pbtt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NVAR_W-1:0] cfg_num_vars,
  // Token input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [VIDX_W-1:0] in_var_index,
  input  logic              in_last,
  // Result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VEC_W-1:0]  out_minterm_mask,
  output logic              out_always_true,
  output logic              out_always_false,
  output logic              out_error
);

  logic [NVAR_W-1:0] num_vars_r;
  logic [NVAR_W-1:0] n_eff;
  logic              tok_valid_r;
  logic [KIND_W-1:0] tok_kind_r;
  logic [VIDX_W-1:0] tok_vidx_r;
  logic              tok_last_r;
  logic              exec_fire;
  logic              in_fire;
  logic [VEC_W-1:0]  push_vec;
  logic [VEC_W-1:0]  top_d;
  stk_cmd_t          cmd;
  stk_stat_t         stat;
  logic [VEC_W-1:0]  rows;
  logic [VEC_W-1:0]  mask;
  logic [NVAR_W-1:0] var_pos;
  logic              out_valid_r;
  logic [VEC_W-1:0]  mask_r;
  logic              always_true_r;
  logic              always_false_r;
  logic              error_r;

  // Configuration register; always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= '0;
    end else if (cfg_valid) begin
      num_vars_r <= cfg_num_vars;
    end
  end

  assign n_eff = (num_vars_r > MAX_VARS) ? MAX_VARS : num_vars_r;

  // Handshake: non-last tokens always proceed; a last token needs a free result slot.
  assign exec_fire = tok_valid_r && (!tok_last_r || !out_valid_r || out_ready);
  assign in_ready  = !tok_valid_r || exec_fire;
  assign in_fire   = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (in_ready) begin
      tok_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tok_kind_r <= in_kind;
      tok_vidx_r <= in_var_index;
      tok_last_r <= in_last;
    end
  end

  // Vector pushed by a constant or variable token.
  assign var_pos = n_eff - NVAR_W'(1) - NVAR_W'(tok_vidx_r);

  always_comb begin
    case (tok_kind_r)
      KIND_CONST1: push_vec = '1;
      KIND_VAR:    push_vec = (NVAR_W'(tok_vidx_r) < n_eff) ? bit_pattern(var_pos) : '0;
      default:     push_vec = '0;
    endcase
  end

  assign cmd.en   = exec_fire;
  assign cmd.kind = tok_kind_r;
  assign cmd.last = tok_last_r;

  pbtt_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .push_vec (push_vec),
    .top_d    (top_d),
    .stat     (stat)
  );

  // Result of the expression from the top of the stack.
  assign rows = row_mask(n_eff);
  assign mask = stat.err ? '0 : (top_d & rows);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire && tok_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && tok_last_r) begin
      mask_r         <= mask;
      always_true_r  <= !stat.err && (mask == rows);
      always_false_r <= (mask == '0);
      error_r        <= stat.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_minterm_mask = mask_r;
  assign out_always_true  = always_true_r;
  assign out_always_false = always_false_r;
  assign out_error        = error_r;

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(exec_fire && tok_last_r))
    else $error("result overwritten while held");

  // An error result carries an empty mask.
  a_err_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && error_r) |-> (mask_r == '0) && always_false_r && !always_true_r)
    else $error("error result with non-empty mask");

  // A result word is valid in the cycle after its last token executes.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && tok_last_r) |=> out_valid_r)
    else $error("last token gave no result");

endmodule

// ===== dv/postfix_boolean_truth_table_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for postfix_boolean_truth_table_core: sends token words, predicts the
// truth-table result word of every expression and checks it field by field.
// Depends on pbtt_pkg and the core RTL; it needs no other files.
module postfix_boolean_truth_table_core_tb;
  import pbtt_pkg::*;

  localparam int unsigned STACK_WORDS = DEF_STACK_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_TOKENS = 120;

  // Expected contents of one result word.
  typedef struct packed {
    logic [VEC_W-1:0] mask;
    logic             all_true;
    logic             all_false;
    logic             err;
  } table_result_t;

  // One token word as the stimulus builds it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VIDX_W-1:0] vidx;
    logic              last;
  } token_t;

  // Keeps its own vector stack, works out each expression's table and checks
  // result words against the oldest table still waiting.
  class truth_table_board;
    logic [VEC_W-1:0]  vectors [STACK_WORDS];
    int unsigned       level;
    bit                broken;
    logic [NVAR_W-1:0] num_vars;
    table_result_t     pending[$];
    int unsigned       mismatches;

    function new();
      level = 0;
      broken = 0;
      num_vars = '0;
      mismatches = 0;
    endfunction

    function void set_num_vars(logic [NVAR_W-1:0] v);
      num_vars = v;
    endfunction

    // A push onto a full stack is dropped and marks the expression as broken.
    function void push_vector(logic [VEC_W-1:0] v);
      if (level >= STACK_WORDS) begin
        broken = 1;
      end else begin
        vectors[level] = v;
        level++;
      end
    endfunction

    function void note_token(logic [KIND_W-1:0] kind, logic [VIDX_W-1:0] vidx, logic last);
      int unsigned      n;
      int               r;
      logic [VEC_W-1:0] col;
      logic [VEC_W-1:0] a;
      logic [VEC_W-1:0] b;
      logic [VEC_W-1:0] rows;
      table_result_t    t;
      bit               bad;
      n = (num_vars > MAX_VARS) ? MAX_VARS : num_vars;
      case (kind)
        KIND_CONST0: push_vector('0);
        KIND_CONST1: push_vector('1);
        KIND_VAR: begin
          // Variable j follows bit (n-1-j) of the row number; unused ones read as zero.
          col = '0;
          if (vidx < n) begin
            for (r = 0; r < VEC_W; r++) col[r] = ((r >> (n - 1 - vidx)) & 1) != 0;
          end
          push_vector(col);
        end
        KIND_NOT: begin
          if (level < 1) broken = 1;
          else vectors[level-1] = ~vectors[level-1];
        end
        KIND_AND, KIND_OR, KIND_XOR, KIND_IMPLIES, KIND_EQUIV: begin
          if (level < 2) begin
            broken = 1;
          end else begin
            b = vectors[level-1];
            a = vectors[level-2];
            level--;
            case (kind)
              KIND_AND:     vectors[level-1] = a & b;
              KIND_OR:      vectors[level-1] = a | b;
              KIND_XOR:     vectors[level-1] = a ^ b;
              KIND_IMPLIES: vectors[level-1] = ~a | b;
              default:      vectors[level-1] = ~(a ^ b);
            endcase
          end
        end
        default: ;
      endcase
      if (last) begin
        bad = broken || level == 0;
        rows = (n >= 6) ? '1 : ((64'd1 << (1 << n)) - 64'd1);
        t.mask = bad ? '0 : (vectors[level-1] & rows);
        t.all_true = !bad && t.mask == rows;
        t.all_false = t.mask == '0;
        t.err = bad;
        pending.insert(pending.size(), t);
        level = 0;
        broken = 0;
      end
    endfunction

    function void compare_field(string name, logic [VEC_W-1:0] want, logic [VEC_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [VEC_W-1:0] mask, logic all_true, logic all_false,
                               logic err);
      table_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected nothing, actual mask %h",
                 $time, mask);
        return;
      end
      want = pending.pop_front();
      compare_field("minterm_mask", want.mask, mask);
      compare_field("always_true", VEC_W'(want.all_true), VEC_W'(all_true));
      compare_field("always_false", VEC_W'(want.all_false), VEC_W'(all_false));
      compare_field("error", VEC_W'(want.err), VEC_W'(err));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [NVAR_W-1:0] cfg_num_vars;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind;
  logic [VIDX_W-1:0] in_var_index;
  logic              in_last;
  logic              out_valid;
  logic              out_ready;
  logic [VEC_W-1:0]  out_minterm_mask;
  logic              out_always_true;
  logic              out_always_false;
  logic              out_error;

  truth_table_board  tt_board;
  int unsigned       send_idle_pct;
  int unsigned       stall_pct;
  int unsigned       token_count;
  int unsigned       cycle_count;

  postfix_boolean_truth_table_core #(
    .STACK_DEPTH(STACK_WORDS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_num_vars    (cfg_num_vars),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_var_index    (in_var_index),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_minterm_mask(out_minterm_mask),
    .out_always_true (out_always_true),
    .out_always_false(out_always_false),
    .out_error       (out_error)
  );

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Note every accepted word on the edge that takes it, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tt_board.set_num_vars(cfg_num_vars);
      if (in_valid && in_ready) tt_board.note_token(in_kind, in_var_index, in_last);
      if (out_valid && out_ready) begin
        tt_board.check_result(out_minterm_mask, out_always_true, out_always_false, out_error);
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one token word, with random idle cycles ahead of it.
  task automatic send_token(input logic [KIND_W-1:0] k, input logic [VIDX_W-1:0] v,
                            input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_var_index <= v;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    token_count++;
  endtask

  task automatic write_num_vars(input logic [NVAR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_num_vars <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline empty. The first edge
  // makes sure the last accepted token has been noted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tt_board.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One expression: mostly well-formed trees, some stack overflows, some noise.
  task automatic send_expression();
    token_t      q[$];
    token_t      t;
    int unsigned shape;
    int unsigned pushes;
    int unsigned made;
    int unsigned depth;
    int unsigned keep;
    int unsigned i;
    shape = $urandom_range(99);
    if (shape < 78) begin
      pushes = ($urandom_range(19) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 8);
      keep = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : 1;
      made = 0;
      depth = 0;
      while (made < pushes || depth > keep) begin
        if (depth >= 2 && (made >= pushes || $urandom_range(2) == 0)) begin
          t.kind = KIND_W'($urandom_range(KIND_AND, KIND_EQUIV));
          depth--;
        end else if (depth >= 1 && $urandom_range(4) == 0) begin
          t.kind = KIND_NOT;
        end else begin
          t.kind = ($urandom_range(3) == 0) ? KIND_W'($urandom_range(KIND_CONST0, KIND_CONST1))
                                            : KIND_VAR;
          made++;
          depth++;
        end
        t.vidx = VIDX_W'($urandom_range(7));
        t.last = 1'b0;
        q.insert(q.size(), t);
      end
    end else if (shape < 81) begin
      // Fill the stack to within one entry of the brim, or beyond it.
      pushes = $urandom_range(STACK_WORDS - 1, STACK_WORDS + 2);
      for (i = 0; i < pushes + $urandom_range(2); i++) begin
        t.kind = (i < pushes) ? KIND_VAR : KIND_W'($urandom_range(KIND_AND, KIND_EQUIV));
        t.vidx = VIDX_W'($urandom_range(7));
        t.last = 1'b0;
        q.insert(q.size(), t);
      end
    end else begin
      for (i = 0; i < $urandom_range(1, 8); i++) begin
        t.kind = KIND_W'($urandom_range(15));
        t.vidx = VIDX_W'($urandom_range(7));
        t.last = ($urandom_range(7) == 0);
        q.insert(q.size(), t);
      end
    end
    q[q.size()-1].last = 1'b1;
    foreach (q[j]) send_token(q[j].kind, q[j].vidx, q[j].last);
  endtask

  initial begin
    logic [NVAR_W-1:0] plan [9];
    int unsigned       phase;
    int unsigned       start;
    plan = '{3'd7, 3'd0, 3'd6, 3'd1, 3'd2, 3'd5, 3'd3, 3'd4, 3'd6};
    tt_board = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_num_vars = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_var_index = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    token_count = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed expressions over three variables.
    write_num_vars(3'd3);
    // (v0 & v1) | v2
    send_token(KIND_VAR, 3'd0, 1'b0);
    send_token(KIND_VAR, 3'd1, 1'b0);
    send_token(KIND_AND, 3'd0, 1'b0);
    send_token(KIND_VAR, 3'd2, 1'b0);
    send_token(KIND_OR, 3'd0, 1'b1);
    // A variable beyond num_vars reads as all zero.
    send_token(KIND_VAR, 3'd7, 1'b1);
    send_token(KIND_CONST1, 3'd0, 1'b1);
    send_token(KIND_CONST0, 3'd0, 1'b0);
    send_token(KIND_NOT, 3'd0, 1'b1);
    // ((v0 ^ v1) -> v2) == v1
    send_token(KIND_VAR, 3'd0, 1'b0);
    send_token(KIND_VAR, 3'd1, 1'b0);
    send_token(KIND_XOR, 3'd0, 1'b0);
    send_token(KIND_VAR, 3'd2, 1'b0);
    send_token(KIND_IMPLIES, 3'd0, 1'b0);
    send_token(KIND_VAR, 3'd1, 1'b0);
    send_token(KIND_EQUIV, 3'd0, 1'b1);
    // Underflow on an empty stack.
    send_token(KIND_AND, 3'd5, 1'b1);
    // Leftover operand below the top.
    send_token(KIND_VAR, 3'd6, 1'b0);
    send_token(KIND_CONST1, 3'd0, 1'b1);
    // Unknown kinds leave the stack alone but still end the expression.
    send_token(4'd15, 3'd0, 1'b1);
    send_token(KIND_VAR, 3'd1, 1'b0);
    send_token(4'd9, 3'd4, 1'b0);
    send_token(4'd12, 3'd2, 1'b1);
    drain();

    // Random phases; each sets a variable count from the plan and an idling pattern from the phase number.
    for (phase = 0; phase < 9; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      write_num_vars(plan[phase]);
      start = token_count;
      while (token_count - start < PHASE_TOKENS) send_expression();
      drain();
    end

    if (tt_board.mismatches == 0 && tt_board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pbtt_pkg.sv
hdl/pbtt_stack.sv
hdl/postfix_boolean_truth_table_core.sv
dv/postfix_boolean_truth_table_core_tb.sv
